[rtl/wsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, codes and constants of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned TOTAL_BITS_DEFAULT = 32;
    localparam logic [31:0] MAX_MESSAGE_RESET  = 32'(4 << 20);

    // header byte fields
    localparam int unsigned FIN_BIT    = 7;
    localparam int unsigned MASK_BIT   = 7;
    localparam logic [6:0]  LEN16_CODE = 7'd126;
    localparam logic [6:0]  LEN64_CODE = 7'd127;

    // header byte counter
    localparam int unsigned CNT_W       = 3;
    localparam logic [2:0]  EXT16_LAST  = 3'd1;
    localparam logic [2:0]  EXT64_LAST  = 3'd7;
    localparam logic [2:0]  MASK_LAST   = 3'd3;

    localparam logic [3:0]  OPCODE_CONT  = 4'h0;
    localparam logic [3:0]  OPCODE_CLOSE = 4'h8;
    localparam logic [3:0]  OPCODE_PING  = 4'h9;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXT16   = 6'b000100,
        PH_EXT64   = 6'b001000,
        PH_MASK    = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        EV_BYTE  = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        CH_DATA  = 2'd0,
        CH_PING  = 2'd1,
        CH_CLOSE = 2'd2,
        CH_SKIP  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [1:0] channel;
        logic [7:0] data_byte;
        logic [3:0] message_opcode;
        logic       last;
    } result_t;

    function automatic kind_t kind_of(input logic [3:0] op);
        kind_t k;
        if (op[3] == 1'b0)
            k = CH_DATA;
        else if (op == OPCODE_PING)
            k = CH_PING;
        else if (op == OPCODE_CLOSE)
            k = CH_CLOSE;
        else
            k = CH_SKIP;
        return k;
    endfunction

endpackage

[rtl/wsd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_in_if / wsd_out_if
// Valid/ready channels of the deframer: received bytes in, parse results out.
// ----------------------------------------------------------------------------
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [1:0] channel;
    logic [7:0] data_byte;
    logic [3:0] message_opcode;
    logic       last;

    modport source (output valid, output event_res, output channel, output data_byte,
                    output message_opcode, output last, input ready);
    modport sink   (input valid, input event_res, input channel, input data_byte,
                    input message_opcode, input last, output ready);
endinterface

[rtl/wsd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Frame parse state and the per-byte step: header, length, mask key, payload.
// ----------------------------------------------------------------------------
module wsd_parser #(
    parameter int unsigned TOTAL_BITS = wsd_pkg::TOTAL_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [7:0]          rx_byte,
    input  logic [31:0]         max_message,
    output logic                res_valid,
    output wsd_pkg::result_t    res
);

    localparam int unsigned SUM_W = ((TOTAL_BITS > 32) ? TOTAL_BITS : 32) + 1;

    wsd_pkg::phase_t              phase_reg,  phase_next;
    logic                         fin_reg,    fin_next;
    logic [3:0]                   opcode_reg, opcode_next;
    logic                         mask_reg,   mask_next;
    logic [31:0]                  len_reg,    len_next;
    logic                         len_hi_reg, len_hi_next;
    logic [wsd_pkg::CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [31:0]                  key_reg,    key_next;
    logic [31:0]                  rem_reg,    rem_next;
    logic [1:0]                   pos_reg,    pos_next;
    logic [TOTAL_BITS-1:0]        total_reg,  total_next;
    logic [3:0]                   first_reg,  first_next;
    logic                         halt_reg,   halt_next;

    always_comb
    begin
        logic            hdr_done;
        logic            need_mask;
        logic [31:0]     n_lo;
        logic            n_hi;
        logic [SUM_W-1:0] sum;
        logic            over;
        wsd_pkg::kind_t  kind;
        logic [2:0]      cnt_last;
        logic [7:0]      key_byte;
        logic [7:0]      db;
        logic            done;
        logic [3:0]      first_upd;

        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        len_hi_next = len_hi_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        first_next  = first_reg;
        halt_next   = halt_reg;

        res_valid          = 1'b0;
        res.event_res      = wsd_pkg::EV_BYTE;
        res.channel        = wsd_pkg::CH_DATA;
        res.data_byte      = 8'h00;
        res.message_opcode = first_reg;
        res.last           = 1'b0;

        hdr_done  = 1'b0;
        need_mask = 1'b0;
        n_lo      = len_reg;
        n_hi      = len_hi_reg;
        kind      = wsd_pkg::kind_of(opcode_reg);
        cnt_last  = (phase_reg == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_LAST
                                                     : wsd_pkg::EXT64_LAST;
        key_byte  = 8'h00;
        db        = 8'h00;
        done      = 1'b0;
        first_upd = first_reg;
        sum       = '0;
        over      = 1'b0;

        if (!halt_reg)
        begin
            unique case (phase_reg)
                wsd_pkg::PH_HDR0:
                begin
                    fin_next    = rx_byte[wsd_pkg::FIN_BIT];
                    opcode_next = rx_byte[3:0];
                    phase_next  = wsd_pkg::PH_HDR1;
                end
                wsd_pkg::PH_HDR1:
                begin
                    mask_next   = rx_byte[wsd_pkg::MASK_BIT];
                    key_next    = 32'h0;
                    cnt_next    = '0;
                    len_next    = 32'h0;
                    len_hi_next = 1'b0;
                    if (rx_byte[6:0] == wsd_pkg::LEN16_CODE)
                        phase_next = wsd_pkg::PH_EXT16;
                    else if (rx_byte[6:0] == wsd_pkg::LEN64_CODE)
                        phase_next = wsd_pkg::PH_EXT64;
                    else
                    begin
                        len_next  = {25'h0, rx_byte[6:0]};
                        n_lo      = {25'h0, rx_byte[6:0]};
                        n_hi      = 1'b0;
                        hdr_done  = 1'b1;
                        need_mask = rx_byte[wsd_pkg::MASK_BIT];
                    end
                end
                wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64:
                begin
                    // bytes shifted past bit 31 only matter as nonzero
                    len_next    = {len_reg[23:0], rx_byte};
                    len_hi_next = len_hi_reg | (len_reg[31:24] != 8'h00);
                    cnt_next    = cnt_reg + 3'd1;
                    if (cnt_reg == cnt_last)
                    begin
                        cnt_next  = '0;
                        n_lo      = len_next;
                        n_hi      = len_hi_next;
                        hdr_done  = 1'b1;
                        need_mask = mask_reg;
                    end
                end
                wsd_pkg::PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == wsd_pkg::MASK_LAST)
                    begin
                        cnt_next = '0;
                        hdr_done = 1'b1;
                    end
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    unique case (pos_reg)
                        2'd0:    key_byte = key_reg[31:24];
                        2'd1:    key_byte = key_reg[23:16];
                        2'd2:    key_byte = key_reg[15:8];
                        default: key_byte = key_reg[7:0];
                    endcase
                    db       = rx_byte ^ key_byte;
                    pos_next = pos_reg + 2'd1;
                    if (rem_reg != 32'h0)
                        rem_next = rem_reg - 32'h1;
                    done = (rem_reg <= 32'h1);
                    if (done)
                        phase_next = wsd_pkg::PH_HDR0;
                    res.data_byte = db;
                    unique case (kind)
                        wsd_pkg::CH_DATA:
                        begin
                            res_valid = 1'b1;
                            res.last  = done & fin_reg;
                            if (done & fin_reg)
                            begin
                                total_next = '0;
                                first_next = 4'h0;
                            end
                        end
                        wsd_pkg::CH_PING:
                        begin
                            res_valid   = 1'b1;
                            res.channel = wsd_pkg::CH_PING;
                            res.last    = done;
                        end
                        wsd_pkg::CH_CLOSE:
                        begin
                            res_valid   = 1'b1;
                            res.channel = wsd_pkg::CH_CLOSE;
                            res.last    = done;
                            if (done)
                                halt_next = 1'b1;
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = wsd_pkg::PH_HDR0;
                end
            endcase

            sum  = SUM_W'(total_reg) + SUM_W'(n_lo);
            over = n_hi || (n_lo > max_message) || (sum > SUM_W'(max_message));

            if (hdr_done && need_mask)
                phase_next = wsd_pkg::PH_MASK;
            else if (hdr_done && over)
            begin
                halt_next     = 1'b1;
                res_valid     = 1'b1;
                res.event_res = wsd_pkg::EV_ERROR;
                res.channel   = (kind == wsd_pkg::CH_SKIP) ? wsd_pkg::CH_DATA : kind;
            end
            else if (hdr_done)
            begin
                rem_next = n_lo;
                pos_next = 2'd0;
                if (kind == wsd_pkg::CH_DATA)
                begin
                    // running total saturates at its own width
                    if (sum[SUM_W-1:TOTAL_BITS] != '0)
                        total_next = '1;
                    else
                        total_next = sum[TOTAL_BITS-1:0];
                    if (opcode_reg != wsd_pkg::OPCODE_CONT && first_reg == 4'h0)
                        first_upd = opcode_reg;
                    first_next = first_upd;
                end
                res.message_opcode = first_upd;
                res.event_res      = wsd_pkg::EV_END;
                res.last           = 1'b1;
                res.channel        = kind;
                if (n_lo != 32'h0)
                    phase_next = wsd_pkg::PH_PAYLOAD;
                else
                begin
                    phase_next = wsd_pkg::PH_HDR0;
                    unique case (kind)
                        wsd_pkg::CH_DATA:
                        begin
                            // empty non-final fragment gives nothing
                            if (fin_reg)
                            begin
                                res_valid  = 1'b1;
                                total_next = '0;
                                first_next = 4'h0;
                            end
                        end
                        wsd_pkg::CH_PING:
                        begin
                            res_valid = 1'b1;
                        end
                        wsd_pkg::CH_CLOSE:
                        begin
                            res_valid = 1'b1;
                            halt_next = 1'b1;
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsd_pkg::PH_HDR0;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'h0;
            mask_reg   <= 1'b0;
            len_reg    <= 32'h0;
            len_hi_reg <= 1'b0;
            cnt_reg    <= '0;
            key_reg    <= 32'h0;
            rem_reg    <= 32'h0;
            pos_reg    <= 2'd0;
            total_reg  <= '0;
            first_reg  <= 4'h0;
            halt_reg   <= 1'b0;
        end
        else if (go)
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            len_hi_reg <= len_hi_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            first_reg  <= first_next;
            halt_reg   <= halt_next;
        end
    end

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt state left without reset");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res_valid && res.event_res == wsd_pkg::EV_ERROR) |=> halt_reg)
        else $error("error result without halt");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsd_pkg::PH_PAYLOAD && !halt_reg) |-> (rem_reg != 32'h0))
        else $error("payload phase with no bytes left");

    a_no_result_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> !res_valid)
        else $error("result while halted");

endmodule

[rtl/websocket_frame_deframer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side websocket frame parser: one byte in, at most one result out.
// ----------------------------------------------------------------------------
//  port          dir   handshake      payload
//  rx            in    valid/ready    rx_byte
//  res           out   valid/ready    event_res, channel, data_byte,
//                                     message_opcode, last
//  cfg_we/wdata  in    write enable   max_message
//
//  one byte per cycle sustained unless res stalls; each byte is registered in
//  the input register, then the parse step writes its result register
//  the parse step is one pass of logic from the input register, no iteration
//  rx.ready holds high while the result register is empty or being taken
//  asynchronous active-low reset; no clearing pass, bytes taken at once
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top #(
    parameter int unsigned TOTAL_BITS = wsd_pkg::TOTAL_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    wsd_in_if.sink      rx,
    wsd_out_if.source   res,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    wsd_pkg::result_t  out_data_reg;
    logic [31:0]       max_message_reg;
    logic              go;
    logic              step_valid;
    wsd_pkg::result_t  step_res;

    assign go       = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || go;

    always_comb
    begin
        if (rx.valid && rx.ready)
            in_valid_next = 1'b1;
        else if (go)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (go)
            out_valid_next = step_valid;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            max_message_reg <= wsd_pkg::MAX_MESSAGE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                max_message_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
        if (go)
            out_data_reg <= step_res;
    end

    wsd_parser #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .rx_byte     (in_byte_reg),
        .max_message (max_message_reg),
        .res_valid   (step_valid),
        .res         (step_res)
    );

    assign res.valid          = out_valid_reg;
    assign res.event_res      = out_data_reg.event_res;
    assign res.channel        = out_data_reg.channel;
    assign res.data_byte      = out_data_reg.data_byte;
    assign res.message_opcode = out_data_reg.message_opcode;
    assign res.last           = out_data_reg.last;

endmodule
